### design/rlfc_pkg.sv
// Shared types, constants and helper functions for the RGB LED fade controller.
// Used by rlfc_engine and rgb_led_fade_controller_core; depends on nothing.
`timescale 1ns / 1ps

package rlfc_pkg;

  localparam int CHANNELS_DEF = 3;   // default number of colour channels
  localparam int PINS_W       = 3;   // width of the led_pins field
  localparam int DUTY_W       = 8;
  localparam int SPEED_W      = 8;
  localparam int COLOUR_W     = 3;
  localparam int BTN_W        = 2;
  localparam int PICK_W       = 3;
  localparam int COLOUR_CODES = 6;   // fade targets span colour codes 1..6

  localparam logic [DUTY_W-1:0]   DUTY_FULL   = 8'hFF;
  localparam logic [DUTY_W-1:0]   DUTY_ZERO   = 8'h00;
  localparam logic [SPEED_W-1:0]  SPEED_STEP  = 8'h40;
  localparam logic [SPEED_W-1:0]  SPEED_MAX   = 8'h80;
  localparam logic [COLOUR_W-1:0] SOLID_RESET = 3'd1;

  // Button bit positions
  localparam int BTN_MODE   = 0;
  localparam int BTN_CHANGE = 1;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CTRL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BTN_W-1:0]   buttons;
    logic [PICK_W-1:0]  random_pick;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] fade_speed;
    logic               solid_mode;
    logic [PINS_W-1:0]  led_pins;
  } result_t;

  // Colour code for the next fade target: (pick mod 6) + 1, never black.
  function automatic logic [COLOUR_W-1:0] fade_code(input logic [PICK_W-1:0] pick);
    logic [COLOUR_W-1:0] code;
    if (pick < PICK_W'(COLOUR_CODES)) begin
      code = COLOUR_W'(pick) + COLOUR_W'(1);
    end else begin
      code = COLOUR_W'(pick) - COLOUR_W'(COLOUR_CODES - 1);
    end
    return code;
  endfunction

endpackage

### design/rlfc_engine.sv
// Controller state and its one-pass update for a single request.
// Depends on rlfc_pkg for item/result types, constants and fade_code().
`timescale 1ns / 1ps

module rlfc_engine #(
  parameter int CHANNELS = rlfc_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rlfc_pkg::item_t   item,
  output rlfc_pkg::result_t result
);

  logic [rlfc_pkg::DUTY_W-1:0]   pwm_counter, pwm_counter_next;
  logic [rlfc_pkg::DUTY_W-1:0]   duty        [CHANNELS];
  logic [rlfc_pkg::DUTY_W-1:0]   duty_next   [CHANNELS];
  logic [rlfc_pkg::DUTY_W-1:0]   target_duty [CHANNELS];
  logic [rlfc_pkg::DUTY_W-1:0]   target_next [CHANNELS];
  logic                          mode_flag, mode_flag_next;
  logic [rlfc_pkg::SPEED_W-1:0]  speed_setting, speed_setting_next;
  logic [rlfc_pkg::COLOUR_W-1:0] solid_colour, solid_colour_next;
  logic [rlfc_pkg::BTN_W-1:0]    previous_buttons, previous_buttons_next;
  logic [rlfc_pkg::PINS_W-1:0]   pin_levels, pin_levels_next;

  logic [rlfc_pkg::BTN_W-1:0]    released;
  logic                          all_reached;
  logic [rlfc_pkg::COLOUR_W-1:0] code;
  logic [rlfc_pkg::SPEED_W:0]    speed_sum;

  always_comb begin
    pwm_counter_next      = pwm_counter;
    mode_flag_next        = mode_flag;
    speed_setting_next    = speed_setting;
    solid_colour_next     = solid_colour;
    previous_buttons_next = previous_buttons;
    pin_levels_next       = pin_levels;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      duty_next[ch]   = duty[ch];
      target_next[ch] = target_duty[ch];
    end
    released    = '0;
    all_reached = 1'b1;
    code        = rlfc_pkg::fade_code(item.random_pick);
    speed_sum   = {1'b0, speed_setting} + {1'b0, rlfc_pkg::SPEED_STEP};

    if (item.kind == rlfc_pkg::KIND_TICK) begin
      pwm_counter_next = pwm_counter + 8'd1;
      pin_levels_next  = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        pin_levels_next[ch] = (duty[ch] <= pwm_counter_next);
      end
    end else begin
      // Fade: step each duty toward its target, pick a new target once all settled
      if (!mode_flag) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (duty[ch] == target_duty[ch]) begin
            duty_next[ch] = duty[ch];
          end else if (duty[ch] < target_duty[ch]) begin
            duty_next[ch] = duty[ch] + 8'd1;
            all_reached   = 1'b0;
          end else begin
            duty_next[ch] = duty[ch] - 8'd1;
            all_reached   = 1'b0;
          end
        end
        if (all_reached) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            target_next[ch] = code[ch] ? rlfc_pkg::DUTY_FULL : rlfc_pkg::DUTY_ZERO;
          end
        end
      end

      released              = previous_buttons & ~item.buttons;
      previous_buttons_next = item.buttons;

      if (released[rlfc_pkg::BTN_MODE]) begin
        mode_flag_next = ~mode_flag;
        if (!mode_flag) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            duty_next[ch] = solid_colour[ch] ? rlfc_pkg::DUTY_ZERO : rlfc_pkg::DUTY_FULL;
          end
        end
      end

      if (released[rlfc_pkg::BTN_CHANGE]) begin
        if (!mode_flag_next) begin
          speed_setting_next = (speed_sum > {1'b0, rlfc_pkg::SPEED_MAX}) ?
                               '0 : speed_sum[rlfc_pkg::SPEED_W-1:0];
        end else begin
          solid_colour_next = solid_colour + 3'd1;
          if (solid_colour_next == '0) begin
            solid_colour_next = rlfc_pkg::SOLID_RESET;
          end
          for (int ch = 0; ch < CHANNELS; ch++) begin
            duty_next[ch] = solid_colour_next[ch] ? rlfc_pkg::DUTY_ZERO :
                                                    rlfc_pkg::DUTY_FULL;
          end
        end
      end
    end

    result.led_pins   = pin_levels_next;
    result.solid_mode = mode_flag_next;
    result.fade_speed = speed_setting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter      <= '0;
      mode_flag        <= 1'b0;
      speed_setting    <= '0;
      solid_colour     <= rlfc_pkg::SOLID_RESET;
      previous_buttons <= '0;
      pin_levels       <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        duty[ch]        <= rlfc_pkg::DUTY_FULL;
        target_duty[ch] <= rlfc_pkg::DUTY_FULL;
      end
    end else if (en) begin
      pwm_counter      <= pwm_counter_next;
      mode_flag        <= mode_flag_next;
      speed_setting    <= speed_setting_next;
      solid_colour     <= solid_colour_next;
      previous_buttons <= previous_buttons_next;
      pin_levels       <= pin_levels_next;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        duty[ch]        <= duty_next[ch];
        target_duty[ch] <= target_next[ch];
      end
    end
  end

  a_colour_nonzero: assert property (@(posedge clk) disable iff (rst)
    solid_colour != '0)
    else $error("solid colour reached black");

  a_speed_legal: assert property (@(posedge clk) disable iff (rst)
    speed_setting == '0 || speed_setting == rlfc_pkg::SPEED_STEP ||
    speed_setting == rlfc_pkg::SPEED_MAX)
    else $error("speed setting left its cycle");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    (en && item.kind == rlfc_pkg::KIND_TICK) |=> pwm_counter == $past(pwm_counter) + 8'd1)
    else $error("PWM counter did not advance on a tick");

endmodule

### design/rgb_led_fade_controller_core.sv
// Top level of the RGB LED fade controller: stream ports, request and result registers.
// Depends on rlfc_pkg and rlfc_engine.
// Path: request register, then result register, which drives m_tvalid and m_tdata.
// Throughput: one request per cycle sustained while m_tready stays high; the request
// register hands over to the engine and result register in the same cycle it is refilled.
// Reset (rst, synchronous, active high): both stages empty, duties and targets 255,
// fade mode, speed 0, solid colour 1, counter, buttons and pins cleared.
`timescale 1ns / 1ps

module rgb_led_fade_controller_core #(
  parameter int CHANNELS = rlfc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] buttons, [4:2] random_pick, [7:5] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] led_pins, [3] solid_mode, [11:4] fade_speed,
                                 // [15:12] zero
);

  // Request register
  logic              in_valid;
  rlfc_pkg::item_t   in_item;
  // Result register
  logic              out_valid;
  rlfc_pkg::result_t out_result;

  rlfc_pkg::result_t step_result;
  logic              advance;

  // Advance the held request whenever the result register is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: capture the request and the step result, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind        <= rlfc_pkg::kind_t'(s_tuser);
      in_item.buttons     <= s_tdata[1:0];
      in_item.random_pick <= s_tdata[4:2];
    end
    if (advance) begin
      out_result <= step_result;
    end
  end

  // State update happens exactly when the request moves into the result register
  rlfc_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (step_result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_result.fade_speed, out_result.solid_mode,
                     out_result.led_pins};

endmodule

### bench/tb.sv
// Self-checking bench for rgb_led_fade_controller_core: drives PWM ticks and control steps,
// predicts every result from its own copy of the LED state and compares field by field.
// Depends on rlfc_pkg and the design sources only.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;

  // Button levels as sent in one sample
  localparam logic [rlfc_pkg::BTN_W-1:0] BTNS_NONE   = 2'b00;
  localparam logic [rlfc_pkg::BTN_W-1:0] BTNS_MODE   = 2'b01;
  localparam logic [rlfc_pkg::BTN_W-1:0] BTNS_CHANGE = 2'b10;
  localparam logic [rlfc_pkg::BTN_W-1:0] BTNS_BOTH   = 2'b11;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [1:0] buttons, [4:2] random_pick, [7:5] zero
  logic        s_tuser;   // [0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [2:0] led_pins, [3] solid_mode, [11:4] fade_speed, [15:12] zero

  rgb_led_fade_controller_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predicted LED controller state
  logic [rlfc_pkg::DUTY_W-1:0]   tick_count;
  logic [rlfc_pkg::DUTY_W-1:0]   duty_lvl  [0:2];
  logic [rlfc_pkg::DUTY_W-1:0]   duty_goal [0:2];
  logic                          in_solid;
  logic [rlfc_pkg::SPEED_W-1:0]  speed_m;
  logic [rlfc_pkg::COLOUR_W-1:0] colour_m;
  logic [rlfc_pkg::BTN_W-1:0]    btn_prev;
  logic [rlfc_pkg::PINS_W-1:0]   pins_m;

  rlfc_pkg::result_t pending_results[$];
  int      mismatches;
  int      cycle_count;

  // Sender and receiver pacing
  int   burst_left;
  logic sender_gaps;
  logic rx_always;
  logic hold_off_req;
  int   drain_style;
  int   drain_span;
  int   drain_phase;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void load_colour();
    for (int c = 0; c < 3; c++) begin
      duty_lvl[c] = colour_m[c] ? rlfc_pkg::DUTY_ZERO : rlfc_pkg::DUTY_FULL;
    end
  endfunction

  // Apply one request to the predicted state and return the result it must produce
  function automatic rlfc_pkg::result_t advance_led_state(
      input rlfc_pkg::kind_t k,
      input logic [rlfc_pkg::BTN_W-1:0] b,
      input logic [rlfc_pkg::PICK_W-1:0] p);
    rlfc_pkg::result_t          r;
    logic [rlfc_pkg::BTN_W-1:0] rel;
    int                         settled;
    int                         code;
    if (k == rlfc_pkg::KIND_TICK) begin
      tick_count = tick_count + 8'd1;
      for (int c = 0; c < 3; c++) begin
        pins_m[c] = (duty_lvl[c] <= tick_count);
      end
    end else begin
      if (!in_solid) begin
        settled = 0;
        for (int c = 0; c < 3; c++) begin
          if (duty_lvl[c] == duty_goal[c]) begin
            settled++;
          end else if (duty_lvl[c] < duty_goal[c]) begin
            duty_lvl[c] = duty_lvl[c] + 8'd1;
          end else begin
            duty_lvl[c] = duty_lvl[c] - 8'd1;
          end
        end
        // pick a new target only once the whole colour has arrived; never black
        if (settled == 3) begin
          code = (int'(p) % 6) + 1;
          for (int c = 0; c < 3; c++) begin
            duty_goal[c] = code[c] ? rlfc_pkg::DUTY_FULL : rlfc_pkg::DUTY_ZERO;
          end
        end
      end
      rel      = btn_prev & ~b;
      btn_prev = b;
      if (rel[rlfc_pkg::BTN_MODE]) begin
        in_solid = ~in_solid;
        if (in_solid) load_colour();
      end
      // change acts on the mode as it stands after any toggle
      if (rel[rlfc_pkg::BTN_CHANGE]) begin
        if (!in_solid) begin
          speed_m = (speed_m == rlfc_pkg::SPEED_MAX) ? 8'd0 : speed_m + rlfc_pkg::SPEED_STEP;
        end else begin
          colour_m = colour_m + 3'd1;
          if (colour_m == 3'd0) colour_m = rlfc_pkg::SOLID_RESET;
          load_colour();
        end
      end
    end
    r.led_pins   = pins_m;
    r.solid_mode = in_solid;
    r.fade_speed = speed_m;
    return r;
  endfunction

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin : watch
    rlfc_pkg::result_t got;
    rlfc_pkg::result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[11:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(got), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.led_pins != want.led_pins)
            report_mismatch("led_pins", int'(got.led_pins), int'(want.led_pins));
          if (got.solid_mode != want.solid_mode)
            report_mismatch("solid_mode", int'(got.solid_mode), int'(want.solid_mode));
          if (got.fade_speed != want.fade_speed)
            report_mismatch("fade_speed", int'(got.fade_speed), int'(want.fade_speed));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(advance_led_state(rlfc_pkg::kind_t'(s_tuser),
                                                    s_tdata[1:0], s_tdata[4:2]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[rgb_led_fade_controller_core] ERROR");
      $finish;
    end
  end

  // Result side: long hold-off when asked, else ready (rx_always) or switching stall patterns
  initial begin
    m_tready    = 1'b0;
    drain_span  = 0;
    drain_style = 0;
    drain_phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready = 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_always) begin
        m_tready = 1'b1;
      end else begin
        if (drain_span == 0) begin
          drain_style = $urandom_range(0, 2);
          drain_span  = $urandom_range(10, 80);
        end
        drain_span--;
        drain_phase++;
        case (drain_style)
          0: begin
            m_tready = 1'b1;
          end
          1: begin
            m_tready = 1'($urandom_range(0, 1));
          end
          default: begin
            m_tready = (drain_phase % 4) != 3;
          end
        endcase
      end
    end
  end

  // Offer one request, in bursts separated by random gaps when sender_gaps is set, and hold it until taken
  task automatic send_request(input rlfc_pkg::kind_t k, input logic [rlfc_pkg::BTN_W-1:0] b,
                              input logic [rlfc_pkg::PICK_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid = 1'b1;
    s_tuser  = k;
    s_tdata  = {3'b000, p, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic press_release(input logic [rlfc_pkg::BTN_W-1:0] b,
                               input logic [rlfc_pkg::PICK_W-1:0] p);
    send_request(rlfc_pkg::KIND_CTRL, b, p);
    send_request(rlfc_pkg::KIND_CTRL, BTNS_NONE, p);
  endtask

  // Reset target, wrapped picks, colour cycle with wrap, speed cycle, double release
  task automatic test_directed();
    send_request(rlfc_pkg::KIND_TICK, BTNS_BOTH, 3'd7);
    send_request(rlfc_pkg::KIND_CTRL, BTNS_NONE, 3'd6);   // settled at reset: pick 6 wraps
    press_release(BTNS_MODE, 3'd0);                // enter solid colour 1
    send_request(rlfc_pkg::KIND_TICK, BTNS_NONE, 3'd0);
    for (int i = 0; i < 5; i++) press_release(BTNS_CHANGE, 3'd5);   // colour 2..6
    send_request(rlfc_pkg::KIND_TICK, BTNS_NONE, 3'd0);
    press_release(BTNS_MODE, 3'd0);                // back to fade, duties now on target
    send_request(rlfc_pkg::KIND_CTRL, BTNS_NONE, 3'd7);   // settled: pick 7 wraps
    for (int i = 0; i < 3; i++) press_release(BTNS_CHANGE, 3'd3);   // 64, 128, 0
    press_release(BTNS_BOTH, 3'd1);                // toggle to solid, then colour 7
    press_release(BTNS_CHANGE, 3'd2);              // colour wraps past 0 to 1
  endtask

  // Long fade stretches with ticks so that duties cross every counter value
  task automatic test_fade_run(input int count);
    int r;
    if (in_solid) press_release(BTNS_MODE, 3'd0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 119);
      if (r < 40)
        send_request(rlfc_pkg::KIND_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      else if (r < 41)
        send_request(rlfc_pkg::KIND_CTRL, BTNS_MODE, 3'($urandom_range(0, 7)));
      else if (r < 45)
        send_request(rlfc_pkg::KIND_CTRL, BTNS_CHANGE, 3'($urandom_range(0, 7)));
      else
        send_request(rlfc_pkg::KIND_CTRL, BTNS_NONE, 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic test_solid_run(input int count);
    int r;
    if (!in_solid) press_release(BTNS_MODE, 3'd4);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 11);
      if (r < 6)
        send_request(rlfc_pkg::KIND_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      else if (r < 8)
        send_request(rlfc_pkg::KIND_CTRL, BTNS_CHANGE, 3'($urandom_range(0, 7)));
      else
        send_request(rlfc_pkg::KIND_CTRL, BTNS_NONE, 3'($urandom_range(0, 7)));
    end
    press_release(BTNS_MODE, 3'd0);
  endtask

  task automatic test_button_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(rlfc_pkg::kind_t'(1'($urandom_range(0, 1))), 2'($urandom_range(0, 3)),
                   3'($urandom_range(0, 7)));
    end
  endtask

  // Stall the result side for a long stretch while requests keep coming
  task automatic test_backpressure(input int count);
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    test_button_noise(count);
    sender_gaps  = 1'b1;
  endtask

  task automatic test_back_to_back(input int count);
    sender_gaps = 1'b0;
    rx_always   = 1'b1;
    test_fade_run(count);
    sender_gaps = 1'b1;
    rx_always   = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = rlfc_pkg::KIND_TICK;
    burst_left   = 0;
    sender_gaps  = 1'b1;
    rx_always    = 1'b0;
    hold_off_req = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    tick_count   = 8'd0;
    for (int c = 0; c < 3; c++) begin
      duty_lvl[c]  = rlfc_pkg::DUTY_FULL;
      duty_goal[c] = rlfc_pkg::DUTY_FULL;
    end
    in_solid = 1'b0;
    speed_m  = 8'd0;
    colour_m = rlfc_pkg::SOLID_RESET;
    btn_prev = BTNS_NONE;
    pins_m   = 3'b000;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fade_run(500);
    test_solid_run(150);
    test_button_noise(200);
    test_backpressure(40);
    test_back_to_back(120);

    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[rgb_led_fade_controller_core] OK");
    end else begin
      $display("[rgb_led_fade_controller_core] ERROR");
    end
    $finish;
  end

endmodule

### rgb_led_fade_controller_core.f
design/rlfc_pkg.sv
design/rlfc_engine.sv
design/rgb_led_fade_controller_core.sv
bench/tb.sv
